### rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Clock is clk, reset is arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every clock edge outside reset.
`define MCTW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define MCTW_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MCTW_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/mctw_pkg.sv
`default_nettype none

package mctw_pkg;

	localparam int NumChannels = 8;
	localparam int ChW = (NumChannels > 1) ? $clog2(NumChannels) : 1;

	localparam int ChanFieldW = 4;
	localparam int ChanCmpW   = ChanFieldW + 1;
	localparam int TimeoutW   = 31;
	localparam int TimeW      = 32;
	localparam int PeriodW    = 16;
	localparam int HandleW    = 3;

	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 16;

	localparam logic [CfgIdxW-1:0] CfgCheckPeriod = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgDryRun      = 2'd1;
	localparam logic [CfgIdxW-1:0] CfgHwBackstop  = 2'd2;

	localparam logic [PeriodW-1:0] CheckPeriodRst = 16'd1000;

	typedef enum logic [1:0] {
		CmdTick     = 2'd0,
		CmdRegister = 2'd1,
		CmdAlive    = 2'd2,
		CmdIdle     = 2'd3
	} cmd_t;

	// controller -> datapath
	typedef struct packed {
		logic latch_item;
		logic do_tick;
		logic do_reg;
		logic do_chan;
		logic scan_step;
		logic emit;
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		cmd_t cmd;
		logic fire;
		logic hit;
		logic scan_last;
	} sts_t;

endpackage

`default_nettype wire

### rtl/mctw_if.sv
`default_nettype none

interface mctw_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [3:0]  channel;
	logic [30:0] expiry_ms;

	modport source (output valid, output cmd, output channel, output expiry_ms, input ready);
	modport sink (input valid, input cmd, input channel, input expiry_ms, output ready);
endinterface

interface mctw_out_if;
	logic        valid;
	logic        ready;
	logic        report_kind;
	logic [2:0]  handle;
	logic        table_full;
	logic        hung;
	logic [2:0]  hung_channel;
	logic [31:0] late_ms;
	logic        feed;
	logic        reset_request;

	modport source (output valid, output report_kind, output handle, output table_full,
		output hung, output hung_channel, output late_ms, output feed,
		output reset_request, input ready);
	modport sink (input valid, input report_kind, input handle, input table_full,
		input hung, input hung_channel, input late_ms, input feed,
		input reset_request, output ready);
endinterface

interface mctw_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/multi_channel_task_watchdog_unit.sv
// Channel  Dir  Payload
// req_in   in   cmd, channel, expiry_ms
// rsp_out  out  report_kind, handle, table_full, hung, hung_channel, late_ms,
//               feed, reset_request
// cfg      in   index, data (0 check_period_ms, 1 dry_run, 2 hw_backstop_present)
//
// One request at a time. Alive, idle and a tick without a check return to idle;
// register goes on to emit; a tick that starts a check enters the scan loop, one
// slot compared per cycle, stopping at the first overdue slot, then goes to emit.
// The result register holds a result until taken; a new request is accepted
// while it waits, and the next result stalls only if the old one is still there.
// arst_n clears the clock, period count and slot flags; cfg is always ready.
`default_nettype none

module multi_channel_task_watchdog_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mctw_in_if.sink    req_in,
	mctw_out_if.source rsp_out,
	mctw_cfg_if.sink   cfg
);

	mctw_pkg::ctl_t ctl;
	mctw_pkg::sts_t sts;

	assign cfg.ready = 1'b1;

	mctw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req_in.valid),
		.in_ready  (req_in.ready),
		.out_valid (rsp_out.valid),
		.out_ready (rsp_out.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	mctw_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.sts           (sts),
		.in_cmd        (req_in.cmd),
		.in_channel    (req_in.channel),
		.in_expiry_ms  (req_in.expiry_ms),
		.cfg_we        (cfg.valid && cfg.ready),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.report_kind   (rsp_out.report_kind),
		.handle        (rsp_out.handle),
		.table_full    (rsp_out.table_full),
		.hung          (rsp_out.hung),
		.hung_channel  (rsp_out.hung_channel),
		.late_ms       (rsp_out.late_ms),
		.feed          (rsp_out.feed),
		.reset_request (rsp_out.reset_request)
	);

endmodule

`default_nettype wire

### rtl/mctw_datapath.sv
`default_nettype none

module mctw_datapath (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire mctw_pkg::ctl_t                    ctl,
	output mctw_pkg::sts_t                         sts,
	input  wire logic [1:0]                        in_cmd,
	input  wire logic [mctw_pkg::ChanFieldW-1:0]   in_channel,
	input  wire logic [mctw_pkg::TimeoutW-1:0]     in_expiry_ms,
	input  wire logic                              cfg_we,
	input  wire logic [mctw_pkg::CfgIdxW-1:0]      cfg_index,
	input  wire logic [mctw_pkg::CfgDataW-1:0]     cfg_data,
	output logic                                   report_kind,
	output logic [mctw_pkg::HandleW-1:0]           handle,
	output logic                                   table_full,
	output logic                                   hung,
	output logic [mctw_pkg::HandleW-1:0]           hung_channel,
	output logic [mctw_pkg::TimeW-1:0]             late_ms,
	output logic                                   feed,
	output logic                                   reset_request
);

	localparam int N = mctw_pkg::NumChannels;

	// configuration
	logic [mctw_pkg::PeriodW-1:0] cfg_period_q;
	logic                         cfg_dry_run_q;
	logic                         cfg_hw_q;

	// latched request
	mctw_pkg::cmd_t                   cmd_q;
	logic [mctw_pkg::ChanFieldW-1:0]  ch_q;
	logic [mctw_pkg::TimeoutW-1:0]    tmo_q;

	// supervisor state
	logic [mctw_pkg::TimeW-1:0]    uptime_q;
	logic [mctw_pkg::PeriodW-1:0]  period_cnt_q;
	logic [N-1:0]                  used_q;
	logic [N-1:0]                  active_q;
	logic [mctw_pkg::TimeoutW-1:0] timeout_q [N];
	logic [mctw_pkg::TimeW-1:0]    last_q    [N];
	logic [mctw_pkg::ChW-1:0]      scan_idx_q;

	// pending result
	logic                           res_kind_q;
	logic [mctw_pkg::HandleW-1:0]   res_handle_q;
	logic                           res_full_q;
	logic                           res_hung_q;
	logic [mctw_pkg::HandleW-1:0]   res_which_q;
	logic [mctw_pkg::TimeW-1:0]     res_late_q;

	logic [mctw_pkg::PeriodW-1:0] cnt_nxt;
	logic [mctw_pkg::PeriodW-1:0] period_eff;
	logic                         fire;
	logic                         any_free;
	logic [mctw_pkg::ChW-1:0]     free_idx;
	logic [mctw_pkg::ChW-1:0]     ch_idx;
	logic                         ch_ok;
	logic [mctw_pkg::TimeW-1:0]   idle_time;
	logic                         hit;

	always_comb begin
		cnt_nxt    = period_cnt_q + 1'b1;
		period_eff = (cfg_period_q == '0) ? mctw_pkg::PeriodW'(1) : cfg_period_q;
		fire       = (cnt_nxt >= period_eff);
	end

	// lowest free slot
	always_comb begin
		any_free = 1'b0;
		free_idx = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				any_free = 1'b1;
				free_idx = mctw_pkg::ChW'(i);
			end
		end
	end

	assign ch_idx = mctw_pkg::ChW'(ch_q);
	assign ch_ok  = ({1'b0, ch_q} < mctw_pkg::ChanCmpW'(N));

	// one slot per scan cycle; differences wrap mod 2^32
	assign idle_time = uptime_q - last_q[scan_idx_q];
	assign hit = used_q[scan_idx_q] && active_q[scan_idx_q] &&
		(idle_time > {1'b0, timeout_q[scan_idx_q]});

	always_comb begin
		sts.cmd       = cmd_q;
		sts.fire      = fire;
		sts.hit       = hit;
		sts.scan_last = (scan_idx_q == mctw_pkg::ChW'(N - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_period_q  <= mctw_pkg::CheckPeriodRst;
			cfg_dry_run_q <= 1'b1;
			cfg_hw_q      <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				mctw_pkg::CfgCheckPeriod: cfg_period_q  <= cfg_data;
				mctw_pkg::CfgDryRun:      cfg_dry_run_q <= cfg_data[0];
				mctw_pkg::CfgHwBackstop:  cfg_hw_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uptime_q     <= '0;
			period_cnt_q <= '0;
			used_q       <= '0;
			active_q     <= '0;
		end else begin
			if (ctl.do_tick) begin
				uptime_q     <= uptime_q + 1'b1;
				period_cnt_q <= fire ? '0 : cnt_nxt;
			end
			if (ctl.do_reg && any_free) begin
				used_q[free_idx]   <= 1'b1;
				active_q[free_idx] <= 1'b1;
			end
			if (ctl.do_chan && ch_ok) begin
				active_q[ch_idx] <= (cmd_q == mctw_pkg::CmdAlive);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.latch_item) begin
			cmd_q <= mctw_pkg::cmd_t'(in_cmd);
			ch_q  <= in_channel;
			tmo_q <= in_expiry_ms;
		end
		if (ctl.do_reg && any_free) begin
			timeout_q[free_idx] <= tmo_q;
			last_q[free_idx]    <= uptime_q;
		end
		if (ctl.do_chan && ch_ok && cmd_q == mctw_pkg::CmdAlive) begin
			last_q[ch_idx] <= uptime_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
		end else if (ctl.do_tick) begin
			scan_idx_q <= '0;
		end else if (ctl.scan_step && !hit && !sts.scan_last) begin
			scan_idx_q <= scan_idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.do_tick) begin
			res_kind_q   <= 1'b1;
			res_handle_q <= '0;
			res_full_q   <= 1'b0;
			res_hung_q   <= 1'b0;
			res_which_q  <= '0;
			res_late_q   <= '0;
		end else if (ctl.do_reg) begin
			res_kind_q   <= 1'b0;
			res_handle_q <= any_free ? mctw_pkg::HandleW'(free_idx) : '0;
			res_full_q   <= !any_free;
			res_hung_q   <= 1'b0;
			res_which_q  <= '0;
			res_late_q   <= '0;
		end else if (ctl.scan_step && hit) begin
			res_hung_q  <= 1'b1;
			res_which_q <= mctw_pkg::HandleW'(scan_idx_q);
			res_late_q  <= idle_time;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			report_kind   <= res_kind_q;
			handle        <= res_handle_q;
			table_full    <= res_full_q;
			hung          <= res_hung_q;
			hung_channel  <= res_which_q;
			late_ms       <= res_late_q;
			feed          <= res_kind_q && !res_hung_q && cfg_hw_q;
			reset_request <= res_kind_q && res_hung_q && !cfg_dry_run_q;
		end
	end

endmodule

`default_nettype wire

### rtl/mctw_ctrl.sv
`default_nettype none
`include "assert_macros.svh"

module mctw_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	input  wire mctw_pkg::sts_t sts,
	output mctw_pkg::ctl_t      ctl
);

	typedef enum logic [3:0] {
		StIdle   = 4'b0001,
		StDecode = 4'b0010,
		StScan   = 4'b0100,
		StEmit   = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == StIdle);
	assign out_valid = out_valid_q;

	always_comb begin
		ctl            = '0;
		state_nxt      = state_q;
		ctl.latch_item = (state_q == StIdle) && in_valid;
		case (state_q)
			StIdle: begin
				if (in_valid) begin
					state_nxt = StDecode;
				end
			end
			StDecode: begin
				case (sts.cmd)
					mctw_pkg::CmdTick: begin
						ctl.do_tick = 1'b1;
						state_nxt   = sts.fire ? StScan : StIdle;
					end
					mctw_pkg::CmdRegister: begin
						ctl.do_reg = 1'b1;
						state_nxt  = StEmit;
					end
					default: begin
						ctl.do_chan = 1'b1;
						state_nxt   = StIdle;
					end
				endcase
			end
			StScan: begin
				ctl.scan_step = 1'b1;
				if (sts.hit || sts.scan_last) begin
					state_nxt = StEmit;
				end
			end
			StEmit: begin
				if (out_free) begin
					ctl.emit  = 1'b1;
					state_nxt = StIdle;
				end
			end
			default: state_nxt = StIdle;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= StIdle;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctl.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`MCTW_ASSERT_IMP(a_emit_free, ctl.emit, out_free, "result overwrites an untaken result")
	`MCTW_ASSERT_NXT(a_emit_hold, state_q == StEmit && out_valid_q && !out_ready, state_q == StEmit, "pending result dropped")
	`MCTW_ASSERT_NXT(a_scan_end, state_q == StScan && sts.scan_last, state_q == StEmit, "scan ran past the last slot")
	`MCTW_ASSERT_NXT(a_accept_decode, in_valid && in_ready, state_q == StDecode && !in_ready, "request not decoded after accept")

endmodule

`default_nettype wire

### bench/tb_multi_channel_task_watchdog_unit.sv
`default_nettype none

module tb_multi_channel_task_watchdog_unit;
	import mctw_pkg::*;

	localparam int LimitCycles = 600000;
	localparam int SettleCycles = 16;
	localparam int HoldCycles = 400;
	localparam int NumPhases = 10;
	localparam int PhaseItems = 193;

	typedef struct packed {
		logic        report_kind;
		logic [2:0]  handle;
		logic        table_full;
		logic        hung;
		logic [2:0]  hung_channel;
		logic [31:0] late_ms;
		logic        feed;
		logic        reset_request;
	} watchdog_report_t;

	// Mirror of the supervisor: slot table, ms clock and expected reports in order.
	class watchdog_scoreboard;
		logic [PeriodW-1:0]  period_cfg;
		bit                  dry;
		bit                  hw;
		logic [TimeW-1:0]    uptime;
		logic [PeriodW-1:0]  ticks_in_period;
		bit                  used[NumChannels];
		bit                  active[NumChannels];
		logic [TimeoutW-1:0] limit_ms[NumChannels];
		logic [TimeW-1:0]    stamp[NumChannels];
		watchdog_report_t    due_reports[$];
		int errors, requests, grants, full_replies, checks, hung_reports;

		function new();
			period_cfg = CheckPeriodRst;
			dry = 1'b1;
			hw = 1'b1;
			uptime = '0;
			ticks_in_period = '0;
			for (int i = 0; i < NumChannels; i++) begin
				used[i] = 1'b0;
				active[i] = 1'b0;
				limit_ms[i] = '0;
				stamp[i] = '0;
			end
			errors = 0;
			requests = 0;
			grants = 0;
			full_replies = 0;
			checks = 0;
			hung_reports = 0;
		endfunction

		function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
			case (idx)
				CfgCheckPeriod: period_cfg = val;
				CfgDryRun: dry = val[0];
				CfgHwBackstop: hw = val[0];
				default: ;
			endcase
		endfunction

		function void note_request(cmd_t c, logic [3:0] ch, logic [TimeoutW-1:0] t);
			watchdog_report_t r;
			logic [PeriodW-1:0] period;
			logic [TimeW-1:0] idle_ms;
			bit found;
			r = '0;
			found = 1'b0;
			requests++;
			case (c)
				CmdTick: begin
					uptime = uptime + 1;
					ticks_in_period = ticks_in_period + 1;
					period = (period_cfg == 0) ? 16'd1 : period_cfg;
					if (ticks_in_period >= period) begin
						ticks_in_period = '0;
						r.report_kind = 1'b1;
						for (int i = 0; i < NumChannels; i++) begin
							if (!found && used[i] && active[i]) begin
								idle_ms = uptime - stamp[i];
								if (idle_ms > {1'b0, limit_ms[i]}) begin
									found = 1'b1;
									r.hung_channel = 3'(i);
									r.late_ms = idle_ms;
								end
							end
						end
						r.hung = found;
						r.feed = !found && hw;
						r.reset_request = found && !dry;
						checks++;
						if (found)
							hung_reports++;
						due_reports.push_back(r);
					end
				end
				CmdRegister: begin
					for (int i = 0; i < NumChannels; i++) begin
						if (!found && !used[i]) begin
							found = 1'b1;
							used[i] = 1'b1;
							active[i] = 1'b1;
							limit_ms[i] = t;
							stamp[i] = uptime;
							r.handle = 3'(i);
						end
					end
					r.table_full = !found;
					if (found)
						grants++;
					else
						full_replies++;
					due_reports.push_back(r);
				end
				default: begin
					// handles past the table are dropped
					if (ch < NumChannels) begin
						if (c == CmdAlive) begin
							active[ch] = 1'b1;
							stamp[ch] = uptime;
						end else begin
							active[ch] = 1'b0;
						end
					end
				end
			endcase
		endfunction

		function void compare_field(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_response(watchdog_report_t got);
			watchdog_report_t want;
			if (due_reports.size() == 0) begin
				$display("%0t: unexpected report, expected none, actual %h", $time, got);
				errors++;
			end else begin
				want = due_reports.pop_front();
				compare_field("report_kind", want.report_kind, got.report_kind);
				compare_field("handle", want.handle, got.handle);
				compare_field("table_full", want.table_full, got.table_full);
				compare_field("hung", want.hung, got.hung);
				compare_field("hung_channel", want.hung_channel, got.hung_channel);
				compare_field("late_ms", want.late_ms, got.late_ms);
				compare_field("feed", want.feed, got.feed);
				compare_field("reset_request", want.reset_request, got.reset_request);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   gaps_on;
	bit   hold_off_req;
	int   hold_left;
	int   cycle_count;

	mctw_in_if  req_if();
	mctw_out_if rsp_if();
	mctw_cfg_if cfg_if();

	watchdog_scoreboard sb = new();

	multi_channel_task_watchdog_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req_in (req_if),
		.rsp_out(rsp_if),
		.cfg    (cfg_if)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > LimitCycles) begin
				$display("tb_multi_channel_task_watchdog_unit failed");
				$finish;
			end
		end
	end

	// Report side: random back-pressure, plus one long hold-off when asked.
	initial begin
		rsp_if.ready <= 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_if.valid && rsp_if.ready)
				sb.check_response({rsp_if.report_kind, rsp_if.handle, rsp_if.table_full,
					rsp_if.hung, rsp_if.hung_channel, rsp_if.late_ms, rsp_if.feed,
					rsp_if.reset_request});
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left = HoldCycles;
			end
			if (!arst_n) begin
				rsp_if.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= gaps_on ? ($urandom_range(0, 99) >= 19) : 1'b1;
			end
		end
	end

	task automatic send_request(cmd_t c, logic [3:0] ch, logic [TimeoutW-1:0] t);
		while (gaps_on && $urandom_range(0, 99) < 19) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.cmd <= c;
		req_if.channel <= ch;
		req_if.expiry_ms <= t;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		sb.note_request(c, ch, t);
	endtask

	task automatic send_random(int reg_pct);
		int pick;
		logic [3:0] ch;
		logic [TimeoutW-1:0] t;
		cmd_t c;
		pick = $urandom_range(0, 99);
		ch = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 7)) : 4'($urandom_range(0, 15));
		t = 31'($urandom());
		if (pick < reg_pct)
			c = CmdRegister;
		else if (pick < reg_pct + 45)
			c = CmdTick;
		else if (pick < reg_pct + 73)
			c = CmdAlive;
		else
			c = CmdIdle;
		send_request(c, ch, t);
	endtask

	// Config only goes in once every report has drained and the block is idle.
	task automatic drain_reports();
		req_if.valid <= 1'b0;
		while (sb.due_reports.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// Leaves valid high; the caller drops it after the last write.
	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= val;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	initial begin
		logic [CfgDataW-1:0] period;
		arst_n = 1'b0;
		gaps_on = 1'b1;
		hold_off_req = 1'b0;
		req_if.valid <= 1'b0;
		req_if.cmd <= CmdTick;
		req_if.channel <= '0;
		req_if.expiry_ms <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= CfgCheckPeriod;
		cfg_if.data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(CfgCheckPeriod, 16'd3);
		write_reg(CfgDryRun, 16'd0);
		write_reg(CfgHwBackstop, 16'd1);
		cfg_if.valid <= 1'b0;

		// alive/idle on unregistered and out-of-range handles
		send_request(CmdAlive, 4'd7, '0);
		send_request(CmdIdle, 4'd6, '0);
		send_request(CmdAlive, 4'd15, 31'h7fffffff);
		send_request(CmdIdle, 4'd8, '0);
		send_request(CmdTick, 4'd0, '0);
		send_request(CmdTick, 4'd0, '0);
		// fill the table, then one more to see the full reply
		send_request(CmdRegister, 4'd0, 31'h7fffffff);
		send_request(CmdRegister, 4'd15, 31'd6);
		send_request(CmdRegister, 4'd0, 31'd3);
		send_request(CmdTick, 4'd0, '0);
		send_request(CmdRegister, 4'd0, 31'd25);
		send_request(CmdRegister, 4'd0, 31'h40000000);
		send_request(CmdRegister, 4'd0, 31'd0);
		send_request(CmdRegister, 4'd0, 31'd12);
		send_request(CmdRegister, 4'd0, 31'd1);
		send_request(CmdRegister, 4'd0, 31'h2aaaaaaa);
		send_request(CmdTick, 4'd0, '0);
		send_request(CmdIdle, 4'd2, '0);
		send_request(CmdTick, 4'd0, '0);
		send_request(CmdAlive, 4'd0, '0);
		send_request(CmdTick, 4'd0, '0);
		send_request(CmdTick, 4'd0, '0);
		drain_reports();

		for (int p = 0; p < NumPhases; p++) begin
			case (p)
				0: period = 16'd1;
				1: period = 16'd0;
				2: period = 16'd65535;
				3: period = 16'd2;
				6: period = 16'hffff;
				default: period = 16'($urandom_range(1, 12));
			endcase
			write_reg(CfgCheckPeriod, period);
			write_reg(CfgDryRun, 16'(p % 2));
			write_reg(CfgHwBackstop, 16'((p / 2) % 2));
			cfg_if.valid <= 1'b0;
			gaps_on = (p != 4);
			if (p == 5)
				hold_off_req = 1'b1;
			for (int k = 0; k < PhaseItems; k++)
				send_random((p == 5 && k < 60) ? 50 : 10);
			drain_reports();
		end

		$display("%0d requests over %0d config phases: %0d grants, %0d full replies",
			sb.requests, NumPhases + 1, sb.grants, sb.full_replies);
		$display("%0d periodic checks, %0d of them reporting a hung channel",
			sb.checks, sb.hung_reports);
		if (sb.errors == 0)
			$display("tb_multi_channel_task_watchdog_unit passed");
		else
			$display("tb_multi_channel_task_watchdog_unit failed");
		$finish;
	end

endmodule

`default_nettype wire
